>>> sv/ecu_pkg.sv
// Shared constants and CRC-6 helper functions for the encoder frame tracker.
package ecu_pkg;

    localparam int ANGLE_BITS_DEF = 14;
    localparam int FRAME_BITS     = 24;
    localparam int PAYLOAD_BITS   = 18;
    localparam int CRC_BITS       = 6;
    localparam int CYCLE_BITS     = 23;
    localparam int POS_BITS       = 24;

    localparam logic [CRC_BITS:0]     CRC_POLY    = 7'h43;
    localparam logic [CYCLE_BITS-1:0] CYCLE_RESET = 23'd16384;

    // Bit-serial CRC-6, most significant payload bit first, zero start value.
    // Only evaluated on constants, to build the parallel parity masks.
    function automatic logic [CRC_BITS-1:0] crc6_calc(input logic [PAYLOAD_BITS-1:0] payload);
        logic [CRC_BITS:0] c;
        c = '0;
        for (int i = PAYLOAD_BITS - 1; i >= 0; i--) begin
            c = {c[CRC_BITS-1:0], 1'b0};
            if (c[CRC_BITS] ^ payload[i]) begin
                c = c ^ CRC_POLY;
            end
            c[CRC_BITS] = 1'b0;
        end
        return c[CRC_BITS-1:0];
    endfunction

    // The CRC is linear in the payload, so CRC bit j is the parity of the
    // payload bits selected by this mask.
    function automatic logic [PAYLOAD_BITS-1:0] crc6_col_mask(input int j);
        logic [PAYLOAD_BITS-1:0] m;
        logic [CRC_BITS-1:0]     c;
        m = '0;
        for (int i = 0; i < PAYLOAD_BITS; i++) begin
            c    = crc6_calc(PAYLOAD_BITS'(1) << i);
            m[i] = c[j];
        end
        return m;
    endfunction

endpackage

>>> sv/ecu_check.sv
// Frame check: parallel CRC-6 compare and angle extraction from a registered frame.
module ecu_check
    import ecu_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic [FRAME_BITS-1:0] i_frame,
    output logic                  o_crc_ok,
    output logic [ANGLE_BITS-1:0] o_angle
);

    logic [PAYLOAD_BITS-1:0] payload;
    logic [CRC_BITS-1:0]     crc;

    assign payload = i_frame[FRAME_BITS-1 -: PAYLOAD_BITS];

    for (genvar j = 0; j < CRC_BITS; j++) begin : g_crc
        localparam logic [PAYLOAD_BITS-1:0] MASK = crc6_col_mask(j);
        assign crc[j] = ^(payload & MASK);
    end

    assign o_crc_ok = (crc == i_frame[CRC_BITS-1:0]);
    assign o_angle  = i_frame[FRAME_BITS-1 -: ANGLE_BITS];

endmodule

>>> sv/ecu_track.sv
// Angle unwrap and logical position tracking, with the result register.
module ecu_track
    import ecu_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [CYCLE_BITS-1:0]        i_cycle,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_crc_ok,
    input  logic [ANGLE_BITS-1:0]        i_angle,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_crc_ok,
    output logic [ANGLE_BITS-1:0]        o_angle_counts,
    output logic signed [ANGLE_BITS:0]   o_angle_step,
    output logic signed [POS_BITS-1:0]   o_logic_position
);

    localparam int SW = ANGLE_BITS + 2;
    localparam int PW = POS_BITS + 2;
    localparam logic signed [SW-1:0] TURN     = SW'(1) << ANGLE_BITS;
    localparam logic signed [SW-1:0] HALF     = SW'(1) << (ANGLE_BITS - 1);
    localparam logic signed [PW-1:0] POS_MAX  = (PW'(1) << (POS_BITS - 1)) - PW'(1);
    localparam logic signed [PW-1:0] POS_MIN  = -(PW'(1) << (POS_BITS - 1));

    logic                        r_valid;
    logic                        r_crc_ok;
    logic [ANGLE_BITS-1:0]       r_prev;
    logic                        r_first;
    logic signed [ANGLE_BITS:0]  r_step;
    logic signed [POS_BITS-1:0]  r_acc;

    logic [ANGLE_BITS-1:0]       prev_eff;
    logic signed [SW-1:0]        diff;
    logic signed [ANGLE_BITS:0]  step;
    logic signed [PW-1:0]        sum;
    logic signed [PW-1:0]        twice;
    logic signed [PW-1:0]        cyc;
    logic signed [PW-1:0]        wrapped;
    logic signed [POS_BITS-1:0]  n_acc;
    logic                        take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        prev_eff = r_first ? i_angle : r_prev;
        diff     = signed'(SW'(i_angle)) - signed'(SW'(prev_eff));
        if (diff > HALF) begin
            diff = diff - TURN;
        end else if (diff < -HALF) begin
            diff = diff + TURN;
        end
        step  = diff[ANGLE_BITS:0];

        sum   = PW'(r_acc) + PW'(step);
        twice = sum <<< 1;
        cyc   = signed'(PW'(i_cycle));
        if (twice > cyc) begin
            wrapped = sum - cyc;
        end else if (twice < -cyc) begin
            wrapped = sum + cyc;
        end else begin
            wrapped = sum;
        end
        if (wrapped > POS_MAX) begin
            n_acc = POS_MAX[POS_BITS-1:0];
        end else if (wrapped < POS_MIN) begin
            n_acc = POS_MIN[POS_BITS-1:0];
        end else begin
            n_acc = wrapped[POS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_first <= 1'b1;
            r_prev  <= '0;
            r_acc   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_crc_ok <= i_crc_ok;
                if (i_crc_ok) begin
                    r_first <= 1'b0;
                    r_prev  <= i_angle;
                    r_acc   <= n_acc;
                    r_step  <= step;
                end else begin
                    r_step  <= '0;
                end
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_crc_ok         = r_crc_ok;
    assign o_angle_counts   = r_prev;
    assign o_angle_step     = r_step;
    assign o_logic_position = r_acc;

endmodule

>>> sv/encoder_frame_crc_and_angle_unwrap.sv
// Top level of the encoder frame checker with angle unwrap and position tracking.
//
// Usage: each item on the frame channel (i_frame_valid, o_frame_ready, i_frame)
// is one raw 24-bit encoder frame. For every accepted item exactly one result
// item leaves on the result channel (o_res_valid, i_res_ready): the CRC flag,
// the last good angle, the wrapped angle step and the logical position.
// The position period is written through i_cfg_we and i_cfg_data while idle.
//
// A frame is captured in the input register; from there the CRC check, the
// unwrap and the position update are computed and loaded into the result
// register. The position accumulator is updated in the same cycle as the
// result register, so while the receiver keeps taking results one item can
// be accepted every cycle and the sustained rate is one item per cycle.
//
// Reset (synchronous, active low) empties both registers, sets the position
// period to one turn, clears the previous angle and the position, and arms
// the first-frame capture. When the receiver stalls, the result register
// holds its item and the input register still takes one more item, after
// which o_frame_ready falls until the result is taken.
module encoder_frame_crc_and_angle_unwrap
    import ecu_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CYCLE_BITS-1:0]       i_cfg_data,
    input  logic                        i_frame_valid,
    output logic                        o_frame_ready,
    input  logic [FRAME_BITS-1:0]       i_frame,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic                        o_crc_ok,
    output logic [ANGLE_BITS-1:0]       o_angle_counts,
    output logic signed [ANGLE_BITS:0]  o_angle_step,
    output logic signed [POS_BITS-1:0]  o_logic_position
);

    // Configured period of the logical position.
    logic [CYCLE_BITS-1:0] r_position_cycle;

    // Input register: the frame waits here for the tracking stage.
    logic                  r_in_valid;
    logic [FRAME_BITS-1:0] r_frame;

    logic                  chk_ok;
    logic [ANGLE_BITS-1:0] chk_angle;
    logic                  trk_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_cycle <= CYCLE_RESET;
        end else if (i_cfg_we) begin
            r_position_cycle <= i_cfg_data;
        end
    end

    // The input register frees up whenever the tracking stage takes its item.
    assign o_frame_ready = !r_in_valid || trk_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (o_frame_ready) begin
                r_in_valid <= i_frame_valid;
            end
            if (i_frame_valid && o_frame_ready) begin
                r_frame <= i_frame;
            end
        end
    end

    ecu_check #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_check (
        .i_frame  (r_frame),
        .o_crc_ok (chk_ok),
        .o_angle  (chk_angle)
    );

    ecu_track #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cycle          (r_position_cycle),
        .i_valid          (r_in_valid),
        .o_ready          (trk_ready),
        .i_crc_ok         (chk_ok),
        .i_angle          (chk_angle),
        .o_valid          (o_res_valid),
        .i_ready          (i_res_ready),
        .o_crc_ok         (o_crc_ok),
        .o_angle_counts   (o_angle_counts),
        .o_angle_step     (o_angle_step),
        .o_logic_position (o_logic_position)
    );

`ifndef SYNTH
    // A failed frame never reports movement.
    a_bad_no_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_crc_ok |-> o_angle_step == '0)
        else $error("step reported for a frame with a bad CRC");

    // A good step always lies within half a turn.
    a_step_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_crc_ok |->
            (o_angle_step <= $signed((ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1))) &&
            (o_angle_step >= -$signed((ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1))))
        else $error("angle step outside half a turn");

    // An empty input register must always be able to take an item.
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_frame_ready)
        else $error("input stall with an empty input register");

    // A bad frame leaves the position and the last angle untouched.
    a_bad_keeps_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_ready ##1 o_res_valid && !o_crc_ok |->
            $stable(o_logic_position) && $stable(o_angle_counts))
        else $error("bad frame changed the tracked state");
`endif

endmodule

>>> tb/sv/encoder_frame_crc_and_angle_unwrap_test.sv
// Self-checking testbench for the encoder frame CRC check, angle unwrap and position tracker.
module encoder_frame_crc_and_angle_unwrap_test;
    import ecu_pkg::*;

    // One full turn of the 14-bit angle, and the signed 24-bit position range.
    localparam int     TURN_COUNTS = 1 << ANGLE_BITS_DEF;
    localparam int     HALF_TURN   = TURN_COUNTS / 2;
    localparam longint POS_MAX     = (longint'(1) << (POS_BITS - 1)) - 1;
    localparam longint POS_MIN     = -(longint'(1) << (POS_BITS - 1));
    // Generous bound on the whole run, several times the slowest correct run.
    localparam int     CYCLE_LIMIT = 300000;
    // Length of the long receiver hold-off that makes the block back up.
    localparam int     LONG_STALL  = 300;

    // Everything the block reports for one frame.
    typedef struct packed {
        logic                           crc_ok;
        logic [ANGLE_BITS_DEF-1:0]      angle;
        logic signed [ANGLE_BITS_DEF:0] step;
        logic signed [POS_BITS-1:0]     position;
    } t_tracker_out;

    // Every input of the block starts at a known value.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CYCLE_BITS-1:0]         i_cfg_data = '0;
    logic                          i_frame_valid = 1'b0;
    logic                          o_frame_ready;
    logic [FRAME_BITS-1:0]         i_frame = '0;
    logic                          o_res_valid;
    logic                          i_res_ready = 1'b0;
    logic                          o_crc_ok;
    logic [ANGLE_BITS_DEF-1:0]     o_angle_counts;
    logic signed [ANGLE_BITS_DEF:0] o_angle_step;
    logic signed [POS_BITS-1:0]    o_logic_position;

    // Frames waiting to be offered, and the results the block still owes us.
    logic [FRAME_BITS-1:0] frames_to_send[$];
    t_tracker_out          results_due[$];

    // Our own copy of the tracker state and of the position period.
    logic [CYCLE_BITS-1:0]     cycle_len = CYCLE_RESET;
    logic [ANGLE_BITS_DEF-1:0] last_angle = '0;
    logic                      awaiting_first = 1'b1;
    int                        tracked_position = 0;

    // The stimulus side keeps its own idea of the encoder angle, so that most
    // frames form a plausible rotation rather than random jumps.
    logic [ANGLE_BITS_DEF-1:0] gen_angle = '0;

    // Idle percentages for sender and receiver, and the long-stall request.
    int send_idle_pct = 28;
    int recv_idle_pct = 79;
    int stall_req = 0;

    int mismatches = 0;
    int frames_queued = 0;
    int frames_good = 0;
    int results_seen = 0;
    int periods_written = 0;
    int saturations = 0;
    int cycle_count = 0;

    encoder_frame_crc_and_angle_unwrap i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_frame_valid    (i_frame_valid),
        .o_frame_ready    (o_frame_ready),
        .i_frame          (i_frame),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_crc_ok         (o_crc_ok),
        .o_angle_counts   (o_angle_counts),
        .o_angle_step     (o_angle_step),
        .o_logic_position (o_logic_position)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Serial CRC-6 over the 18 payload bits, most significant bit first, from
    // a zero register. The top bit of the polynomial only ever cancels the
    // bit shifted out, so only its lower six bits are folded back in.
    function automatic logic [CRC_BITS-1:0] crc6_of(input logic [PAYLOAD_BITS-1:0] bits);
        logic [CRC_BITS-1:0] r;
        logic                fb;
        r = '0;
        for (int k = PAYLOAD_BITS - 1; k >= 0; k--) begin
            fb = r[CRC_BITS-1] ^ bits[k];
            r = {r[CRC_BITS-2:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY[CRC_BITS-1:0];
            end
        end
        return r;
    endfunction

    // Builds a frame with a correct CRC, then flips the bits given in flip.
    function automatic logic [FRAME_BITS-1:0] make_frame(input logic [ANGLE_BITS_DEF-1:0] angle,
                                                         input logic [3:0] status,
                                                         input logic [FRAME_BITS-1:0] flip);
        logic [PAYLOAD_BITS-1:0] body;
        body = {angle, status};
        return {body, crc6_of(body)} ^ flip;
    endfunction

    // Advances our copy of the tracker by one frame and returns what the
    // block must report for it. A frame with a bad CRC leaves the state alone
    // and reports the last good angle, a zero step and the held position.
    function automatic t_tracker_out track_frame(input logic [FRAME_BITS-1:0] frame);
        t_tracker_out              r;
        logic [ANGLE_BITS_DEF-1:0] angle;
        longint                    d;
        longint                    s;
        longint                    c;
        angle = frame[FRAME_BITS-1 -: ANGLE_BITS_DEF];
        r.crc_ok = (crc6_of(frame[FRAME_BITS-1:CRC_BITS]) == frame[CRC_BITS-1:0]);
        r.step = '0;
        if (r.crc_ok) begin
            frames_good++;
            // The first good frame after reset only sets the reference angle.
            if (awaiting_first) begin
                awaiting_first = 1'b0;
                last_angle = angle;
            end
            // Bring the change into one half turn, a single correction only.
            d = longint'(angle) - longint'(last_angle);
            if (d > HALF_TURN) begin
                d -= TURN_COUNTS;
            end else if (d < -HALF_TURN) begin
                d += TURN_COUNTS;
            end
            last_angle = angle;
            // Add to the position and wrap once by the period. A zero period
            // never wraps, so the sum can then run into the saturation limits.
            c = longint'(cycle_len);
            s = longint'(tracked_position) + d;
            if (2 * s > c) begin
                s -= c;
            end else if (2 * s < -c) begin
                s += c;
            end
            if (s > POS_MAX) begin
                s = POS_MAX;
                saturations++;
            end else if (s < POS_MIN) begin
                s = POS_MIN;
                saturations++;
            end
            tracked_position = int'(s);
            r.step = (ANGLE_BITS_DEF + 1)'(d);
        end
        r.angle = last_angle;
        r.position = POS_BITS'(tracked_position);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Random frames that mostly describe a rotating shaft: small moves, moves
    // right at the half-turn boundary, arbitrary jumps and standstill. About
    // one in ten carries a single flipped bit, one in ten is pure noise.
    task automatic push_random(input int count);
        int                        delta;
        int                        pick;
        logic [ANGLE_BITS_DEF-1:0] next_angle;
        logic [FRAME_BITS-1:0]     fr;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                delta = $urandom_range(0, TURN_COUNTS - 1);
            end else if (pick == 1) begin
                delta = HALF_TURN - 1 + $urandom_range(0, 2);
                if ($urandom_range(0, 1)) begin
                    delta = -delta;
                end
            end else if (pick <= 6) begin
                delta = int'($urandom_range(0, 128)) - 64;
            end else if (pick <= 8) begin
                delta = int'($urandom_range(0, TURN_COUNTS)) - HALF_TURN;
            end else begin
                delta = 0;
            end
            next_angle = gen_angle + ANGLE_BITS_DEF'(delta);
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                fr = make_frame(next_angle, 4'($urandom_range(0, 15)), '0);
                gen_angle = next_angle;
            end else if (pick == 8) begin
                fr = make_frame(next_angle, 4'($urandom_range(0, 15)),
                                FRAME_BITS'(1) << $urandom_range(0, FRAME_BITS - 1));
            end else begin
                fr = FRAME_BITS'($urandom());
            end
            frames_to_send.push_back(fr);
            frames_queued++;
        end
    endtask

    // Frames that keep turning one way by up to nearly half a turn each, so that
    // with a zero period the position climbs (or falls) without wrapping.
    task automatic push_drift(input int count, input int dir);
        int delta;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85) begin
                delta = HALF_TURN - 1;
            end else begin
                delta = $urandom_range(HALF_TURN / 2, HALF_TURN - 1);
            end
            if ($urandom_range(0, 9) == 0) begin
                frames_to_send.push_back(make_frame(gen_angle + ANGLE_BITS_DEF'(dir * delta),
                                         4'($urandom_range(0, 15)),
                                         FRAME_BITS'(1) << $urandom_range(0, FRAME_BITS - 1)));
            end else begin
                gen_angle = gen_angle + ANGLE_BITS_DEF'(dir * delta);
                frames_to_send.push_back(make_frame(gen_angle, 4'($urandom_range(0, 15)), '0));
            end
            frames_queued++;
        end
    endtask

    // Waits until every frame has gone and every result has
    // come, then lets the pipeline settle.
    task automatic wait_drained();
        while (frames_to_send.size() != 0 || i_frame_valid || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the position period; only ever called with the block idle.
    task automatic write_cycle(input logic [CYCLE_BITS-1:0] period);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= period;
        cycle_len = period;
        periods_written++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_setting(input logic [CYCLE_BITS-1:0] period, input int count);
        write_cycle(period);
        push_random(count);
        wait_drained();
    endtask

    // Sender: offers the next queued frame unless it decides to idle, and
    // holds valid and payload steady until the block takes the item. Each
    // accepted frame is fed straight into our tracker copy.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_frame_valid <= 1'b0;
        end else begin
            if (i_frame_valid && o_frame_ready) begin
                results_due.push_back(track_frame(i_frame));
            end
            if (!i_frame_valid || o_frame_ready) begin
                if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_frame_valid <= 1'b1;
                    i_frame <= frames_to_send.pop_front();
                end else begin
                    i_frame_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result item against the oldest expectation, then
    // chooses its ready for the next cycle. A new stall request starts a long
    // hold-off that it counts down itself.
    int stall_seen = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_tracker_out want;
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result item with nothing outstanding, crc_ok %b position %h",
                             $time, o_crc_ok, o_logic_position);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    results_seen++;
                    check_field("crc_ok", 32'(want.crc_ok), 32'(o_crc_ok));
                    check_field("angle_counts", 32'(want.angle), 32'(o_angle_counts));
                    check_field("angle_step", 32'(unsigned'(want.step)),
                                32'(unsigned'(o_angle_step)));
                    check_field("logic_position", 32'(unsigned'(want.position)),
                                32'(unsigned'(o_logic_position)));
                end
            end
            if (stall_seen != stall_req) begin
                stall_seen = stall_req;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int rounds;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames with the reset period of one turn. A bad frame
        // comes before any good one, then the first good frame, steps right
        // on and just past the half-turn boundary in both directions, the
        // position sitting exactly on half a period and just over it,
        // all-zero and all-one frames, and flips in the angle and CRC bits.
        frames_to_send.push_back(make_frame(14'd5, 4'h0, 24'h000001));
        frames_to_send.push_back(make_frame(14'h3FFF, 4'hF, '0));
        frames_to_send.push_back(make_frame(14'd0, 4'h0, '0));
        frames_to_send.push_back(make_frame(14'd8192, 4'h0, '0));
        frames_to_send.push_back(make_frame(14'd0, 4'h0, '0));
        frames_to_send.push_back(make_frame(14'd8193, 4'hA, '0));
        frames_to_send.push_back(make_frame(14'd0, 4'h5, '0));
        frames_to_send.push_back(make_frame(14'd8191, 4'h0, '0));
        frames_to_send.push_back(make_frame(14'd8191, 4'hF, '0));
        frames_to_send.push_back(make_frame(14'd8192, 4'h0, '0));
        frames_to_send.push_back(make_frame(14'd0, 4'h3, '0));
        frames_to_send.push_back(make_frame(14'h2AAA, 4'hA, 24'h800000));
        frames_to_send.push_back(24'h000000);
        frames_to_send.push_back(24'hFFFFFF);
        frames_to_send.push_back(make_frame(14'h1555, 4'h5, 24'h000020));
        frames_to_send.push_back(make_frame(14'h1555, 4'h5, '0));
        frames_to_send.push_back(make_frame(14'h3FFF, 4'hF, 24'h000001));
        frames_to_send.push_back(make_frame(14'd0, 4'hC, '0));
        frames_queued += 18;
        wait_drained();

        // Busy sender, lazy receiver: the smallest legal period, one turn and
        // a random mid-range period.
        run_setting(23'd2, 40);
        run_setting(CYCLE_RESET, 40);
        run_setting(CYCLE_BITS'($urandom_range(3, 100000)), 40);

        // Lazy sender, busy receiver: a period below the range, a small one and
        // the largest legal period.
        send_idle_pct <= 79;
        recv_idle_pct <= 28;
        run_setting(23'd1, 40);
        run_setting(23'd3, 40);
        run_setting(23'd4194304, 40);

        // Neither side idles. The all-ones period, then a random period with
        // a long receiver hold-off while the sender keeps offering items, so
        // that the block backs up and stops accepting.
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_setting(23'h7FFFFF, 40);
        write_cycle(CYCLE_BITS'($urandom_range(2, 4194304)));
        push_random(60);
        stall_req <= stall_req + 1;
        wait_drained();
        run_setting(CYCLE_RESET, 40);

        // With a zero period the position never wraps: drive it up until it
        // saturates, push against the limit, then come back down a little.
        write_cycle('0);
        rounds = 0;
        while (longint'(tracked_position) != POS_MAX && rounds < 14) begin
            push_drift(128, 1);
            wait_drained();
            rounds++;
        end
        push_drift(16, 1);
        push_drift(16, -1);
        wait_drained();

        // Large and normal periods pull the position back into range.
        run_setting(23'd4194304, 40);
        run_setting(CYCLE_RESET, 40);

        $display("Summary: %0d frames offered, %0d with a valid CRC, %0d results checked.",
                 frames_queued, frames_good, results_seen);
        $display("Summary: %0d position periods written, position saturated %0d times.",
                 periods_written, saturations);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/ecu_pkg.sv
sv/ecu_check.sv
sv/ecu_track.sv
sv/encoder_frame_crc_and_angle_unwrap.sv
tb/sv/encoder_frame_crc_and_angle_unwrap_test.sv
